@@ rtl/gibs_pkg.sv @@
// Shared types and constants for the greedy IoU box suppression block.
// This file has no dependencies. Every other file in rtl imports it.
package gibs_pkg;

    localparam int SCORE_BITS = 16;
    localparam int THR_BITS   = 17;
    localparam int OUT_CAP    = 64;
    localparam int EMIT_BITS  = 7;
    localparam int IDX_OUT    = 6;
    localparam int PIPE_DEPTH = 4;
    localparam int FIELD_BITS = 12;

    localparam logic        REG_IOU_THR   = 1'b0;
    localparam logic [16:0] THR_RESET_VAL = 17'd32768;

    typedef enum logic [1:0] {
        PH_LOAD,
        PH_PASS,
        PH_EMIT,
        PH_CLEAR
    } t_phase;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

@@ rtl/gibs_cell.sv @@
// One cell of the box ring: holds one box entry and takes its neighbor's
// entry on every shift. Depends on gibs_pkg.
module gibs_cell import gibs_pkg::*; #(
    parameter int EW = 68
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_ctrl    i_ctrl,
    input  logic          i_load,
    input  logic [EW-1:0] i_load_ent,
    input  logic [EW-1:0] i_next_ent,
    output logic [EW-1:0] o_ent
);

    // The three lowest bits are the valid, done and suppressed flags.
    logic [EW-4:0] r_data;
    logic [2:0]    r_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= 3'b000;
        end else if (i_ctrl.clear) begin
            r_flags <= 3'b000;
        end else if (i_load) begin
            r_flags <= i_load_ent[2:0];
        end else if (i_ctrl.shift) begin
            r_flags <= i_next_ent[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_load_ent[EW-1:3];
        end else if (i_ctrl.shift) begin
            r_data <= i_next_ent[EW-1:3];
        end
    end

    assign o_ent = {r_data, r_flags};

endmodule

@@ rtl/gibs_iou.sv @@
// Four-stage overlap test between a passing box and the held candidate.
// It also closes the ring between the last cell and the first. Depends on gibs_pkg.
module gibs_iou import gibs_pkg::*; #(
    parameter int C  = 12,
    parameter int IW = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_shift,
    input  logic [THR_BITS-1:0]     i_thr,
    input  logic [4*C+SCORE_BITS+IW+2:0] i_cand,
    input  logic [4*C+SCORE_BITS+IW+2:0] i_ent,
    output logic [4*C+SCORE_BITS+IW+2:0] o_ent,
    output logic                    o_hit
);

    localparam int SW = C + 2;
    localparam int PW = 2 * C + 2;
    localparam int AW = 2 * C + 4;
    localparam int UW = 2 * C + 6;
    localparam int QW = 2 * C + 5;
    localparam int RW = QW + THR_BITS;

    typedef struct packed {
        logic [C-1:0]          lx;
        logic [C-1:0]          ty;
        logic [C-1:0]          rx;
        logic [C-1:0]          by;
        logic [SCORE_BITS-1:0] score;
        logic [IW-1:0]         idx;
        logic                  valid;
        logic                  done;
        logic                  supp;
    } t_entry;

    t_entry e, c;
    t_entry r1_ent, r2_ent, r3_ent, r4_ent;
    logic [C-1:0] x1, y1, x2, y2;
    logic signed [SW-1:0] iw, ih, wa, ha, wb, hb;
    logic signed [SW-1:0] r1_wa, r1_ha, r1_wb, r1_hb;
    logic [C:0]  r1_iw, r1_ih;
    logic [PW-1:0] r2_inter, r3_inter;
    logic signed [AW-1:0] r2_aa, r2_ab;
    logic signed [UW-1:0] uni;
    logic [QW-1:0] r3_uni;
    logic r3_pos, r4_pos;
    logic [RW-1:0] r4_lhs, r4_rhs;

    assign e = i_ent;
    assign c = i_cand;

    always_comb begin
        x1 = (e.lx > c.lx) ? e.lx : c.lx;
        y1 = (e.ty > c.ty) ? e.ty : c.ty;
        x2 = (e.rx < c.rx) ? e.rx : c.rx;
        y2 = (e.by < c.by) ? e.by : c.by;
        iw = $signed({2'b00, x2}) - $signed({2'b00, x1}) + $signed(SW'(1));
        ih = $signed({2'b00, y2}) - $signed({2'b00, y1}) + $signed(SW'(1));
        wa = $signed({2'b00, e.rx}) - $signed({2'b00, e.lx}) + $signed(SW'(1));
        ha = $signed({2'b00, e.by}) - $signed({2'b00, e.ty}) + $signed(SW'(1));
        wb = $signed({2'b00, c.rx}) - $signed({2'b00, c.lx}) + $signed(SW'(1));
        hb = $signed({2'b00, c.by}) - $signed({2'b00, c.ty}) + $signed(SW'(1));
        uni = $signed(UW'(r2_aa)) + $signed(UW'(r2_ab)) - $signed(UW'(r2_inter));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ent.valid <= 1'b0;
            r2_ent.valid <= 1'b0;
            r3_ent.valid <= 1'b0;
            r4_ent.valid <= 1'b0;
        end else if (i_shift) begin
            r1_ent <= e;
            r2_ent <= r1_ent;
            r3_ent <= r2_ent;
            r4_ent <= r3_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r1_iw    <= iw[SW-1] ? '0 : iw[C:0];
            r1_ih    <= ih[SW-1] ? '0 : ih[C:0];
            r1_wa    <= wa;
            r1_ha    <= ha;
            r1_wb    <= wb;
            r1_hb    <= hb;
            r2_inter <= PW'(r1_iw) * PW'(r1_ih);
            r2_aa    <= $signed(AW'(r1_wa)) * $signed(AW'(r1_ha));
            r2_ab    <= $signed(AW'(r1_wb)) * $signed(AW'(r1_hb));
            r3_inter <= r2_inter;
            r3_pos   <= (uni > $signed(UW'(0)));
            r3_uni   <= uni[QW-1:0];
            r4_pos   <= r3_pos;
            r4_lhs   <= RW'({r3_inter, 16'h0000});
            r4_rhs   <= RW'(i_thr) * RW'(r3_uni);
        end
    end

    assign o_ent = r4_ent;
    assign o_hit = r4_pos && (r4_lhs >= r4_rhs);

endmodule

@@ rtl/greedy_iou_box_suppression.sv @@
// Top level of the greedy IoU box suppression block: ring of box cells,
// overlap pipeline, sequencer and ports. Depends on gibs_pkg, gibs_cell, gibs_iou.
//
// channel   | direction | word
// s_axis    | in        | tdata: box corners and score, tlast: last box of set
// m_axis    | out       | tdata: kept index, tlast: last kept index
// apb       | in/out    | one register, iou_threshold, at byte address 0
//
// Boxes are accepted only in the load phase. After the last box, every pass
// rotates the ring of MAX_BOXES cells plus four pipeline stages once. The
// output rotation stalls while m_axis is held. Reset is synchronous and
// clears all valid flags.
module greedy_iou_box_suppression import gibs_pkg::*; #(
    parameter int MAX_BOXES  = 64,
    parameter int COORD_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] left_x, [23:12] top_y, [35:24] right_x, [47:36] bottom_y,
    // [63:48] box_score
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] kept_index, [7:6] zero
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int C    = COORD_BITS;
    localparam int IW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int KW   = $clog2(MAX_BOXES + 1);
    localparam int CW   = (KW > EMIT_BITS) ? KW : EMIT_BITS;
    localparam int EW   = 4 * C + SCORE_BITS + IW + 3;
    localparam int RING = MAX_BOXES + PIPE_DEPTH;
    localparam int STW  = $clog2(RING);

    typedef struct packed {
        logic [C-1:0]          lx;
        logic [C-1:0]          ty;
        logic [C-1:0]          rx;
        logic [C-1:0]          by;
        logic [SCORE_BITS-1:0] score;
        logic [IW-1:0]         idx;
        logic                  valid;
        logic                  done;
        logic                  supp;
    } t_entry;

    t_phase r_state, n_state;
    t_cell_ctrl ctrl;
    logic [THR_BITS-1:0] r_thr;
    logic [KW-1:0] r_count, r_kept;
    logic [STW-1:0] r_step;
    logic [EMIT_BITS-1:0] r_emitted;
    t_entry r_cand, r_best, n_best, load_ent, exit_ent, upd_ent;
    logic r_best_valid, n_best_valid;
    logic r_out_valid, r_out_last;
    logic [IDX_OUT-1:0] r_out_idx;
    logic in_acc, cfg_wr, hit, step_end, take_best, mark_done, emit_hit, emit_last;
    logic [EW-1:0] ent_q [MAX_BOXES];
    logic [EW-1:0] pipe_out;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IOU_THR) ? 32'(r_thr) : 32'h0;

    always_comb begin
        load_ent.lx    = C'(s_axis_tdata[11:0]);
        load_ent.ty    = C'(s_axis_tdata[23:12]);
        load_ent.rx    = C'(s_axis_tdata[35:24]);
        load_ent.by    = C'(s_axis_tdata[47:36]);
        load_ent.score = s_axis_tdata[63:48];
        load_ent.idx   = r_count[IW-1:0];
        load_ent.valid = 1'b1;
        load_ent.done  = 1'b0;
        load_ent.supp  = 1'b0;
    end

    for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
        logic [EW-1:0] nxt;
        if (k == MAX_BOXES - 1) begin : g_tail
            assign nxt = upd_ent;
        end else begin : g_mid
            assign nxt = ent_q[k + 1];
        end
        gibs_cell #(.EW(EW)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (ctrl),
            .i_load     (in_acc && (r_count == KW'(k))),
            .i_load_ent (load_ent),
            .i_next_ent (nxt),
            .o_ent      (ent_q[k])
        );
    end

    gibs_iou #(.C(C), .IW(IW)) u_iou (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (ctrl.shift),
        .i_thr   (r_thr),
        .i_cand  (r_cand),
        .i_ent   (ent_q[0]),
        .o_ent   (pipe_out),
        .o_hit   (hit)
    );

    assign exit_ent = pipe_out;
    assign step_end = ctrl.shift && (r_step == STW'(RING - 1));

    always_comb begin
        upd_ent      = exit_ent;
        n_best       = r_best;
        n_best_valid = r_best_valid;
        mark_done    = 1'b0;
        if (r_state == PH_PASS && exit_ent.valid && !exit_ent.done && !exit_ent.supp) begin
            if (r_cand.valid && exit_ent.idx == r_cand.idx) begin
                upd_ent.done = 1'b1;
                mark_done    = 1'b1;
            end else if (r_cand.valid && hit) begin
                upd_ent.supp = 1'b1;
            end else if (!r_best_valid || exit_ent.score > r_best.score) begin
                n_best       = exit_ent;
                n_best_valid = 1'b1;
            end
        end
        take_best = (r_state == PH_PASS) && step_end;
        emit_hit  = (r_state == PH_EMIT) && ctrl.shift && exit_ent.valid && exit_ent.done
                    && (r_emitted < EMIT_BITS'(OUT_CAP));
        emit_last = (CW'(r_emitted) + CW'(1) == CW'(OUT_CAP))
                    || (CW'(r_emitted) + CW'(1) == CW'(r_kept));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            PH_LOAD: begin
                if (in_acc && s_axis_tlast) n_state = PH_PASS;
            end
            PH_PASS: begin
                if (take_best && !n_best_valid) n_state = PH_EMIT;
            end
            PH_EMIT: begin
                if (step_end) n_state = PH_CLEAR;
            end
            PH_CLEAR: n_state = PH_LOAD;
            default:  n_state = PH_LOAD;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        ctrl.shift    = 1'b0;
        ctrl.clear    = 1'b0;
        unique case (r_state)
            PH_LOAD:  s_axis_tready = 1'b1;
            PH_PASS:  ctrl.shift = 1'b1;
            PH_EMIT:  ctrl.shift = !r_out_valid || m_axis_tready;
            PH_CLEAR: ctrl.clear = 1'b1;
            default:  ctrl.shift = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= PH_LOAD;
            r_thr        <= THR_RESET_VAL;
            r_count      <= '0;
            r_kept       <= '0;
            r_step       <= '0;
            r_emitted    <= '0;
            r_cand.valid <= 1'b0;
            r_best_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr && paddr[2] == REG_IOU_THR) r_thr <= pwdata[THR_BITS-1:0];
            if (in_acc && r_count < KW'(MAX_BOXES)) r_count <= r_count + KW'(1);
            if (in_acc && s_axis_tlast) begin
                r_cand.valid <= 1'b0;
                r_best_valid <= 1'b0;
                r_kept       <= '0;
                r_emitted    <= '0;
                r_step       <= '0;
            end
            if (ctrl.shift) r_step <= step_end ? '0 : r_step + STW'(1);
            if (mark_done) r_kept <= r_kept + KW'(1);
            if (r_state == PH_PASS) begin
                r_best_valid <= take_best ? 1'b0 : n_best_valid;
                if (take_best) begin
                    r_cand.valid <= n_best_valid;
                    r_cand.lx    <= n_best.lx;
                    r_cand.ty    <= n_best.ty;
                    r_cand.rx    <= n_best.rx;
                    r_cand.by    <= n_best.by;
                    r_cand.score <= n_best.score;
                    r_cand.idx   <= n_best.idx;
                    r_cand.done  <= n_best.done;
                    r_cand.supp  <= n_best.supp;
                end
            end
            if (r_state == PH_CLEAR) r_count <= '0;
            if (emit_hit) begin
                r_out_valid <= 1'b1;
                r_emitted   <= r_emitted + EMIT_BITS'(1);
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == PH_PASS) begin
            r_best <= n_best;
        end
        if (emit_hit) begin
            r_out_idx  <= IDX_OUT'(exit_ent.idx);
            r_out_last <= emit_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_idx};
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != PH_LOAD) |-> (r_kept <= r_count)) else $error("kept count exceeds box count");
    a_emit_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitted <= EMIT_BITS'(OUT_CAP)) else $error("emitted more than the cap");
    a_clear_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == PH_CLEAR) |=> (ent_q[0][2] == 1'b0)) else $error("cell not cleared");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == PH_LOAD) |-> !ctrl.shift) else $error("ring moved while loading");
`endif

endmodule
